/* rtl/vom_pkg.sv */
// Shared types and constants for the voxel occupancy map.
// Depends on nothing; imported by every file of the block but vom_store and vom_checker.
`timescale 1ns / 1ps
`default_nettype none

package vom_pkg;

    // Field widths
    localparam int COORD_W    = 16;
    localparam int RES_W      = 10;
    localparam int SIDE_CFG_W = 7;
    localparam int CFG_AW     = 2;
    localparam int CFG_DW     = 10;

    // Occupancy store row: 32 voxel bits per memory word
    localparam int ROW_BITS = 32;
    localparam int ROW_SH   = 5;

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] REG_RESOLUTION  = 2'd0;
    localparam logic [CFG_AW-1:0] REG_GRID_WIDTH  = 2'd1;
    localparam logic [CFG_AW-1:0] REG_GRID_HEIGHT = 2'd2;
    localparam logic [CFG_AW-1:0] REG_GRID_DEPTH  = 2'd3;

    // Item actions
    localparam logic ACT_QUERY = 1'b0;
    localparam logic ACT_SET   = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_CHECK,
        ST_MUL1,
        ST_MUL2,
        ST_READ,
        ST_FINISH
    } state_t;

    // One input word after unpacking
    typedef struct packed {
        logic                      action;
        logic signed [COORD_W-1:0] x_pos;
        logic signed [COORD_W-1:0] y_pos;
        logic signed [COORD_W-1:0] z_pos;
        logic                      occupied_value;
    } item_t;

    // Controller to datapath
    typedef struct packed {
        logic clr_step;
        logic load;
        logic div_step;
        logic check;
        logic mul1;
        logic mul2;
        logic mem_rd;
        logic finish;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clr_done;
        logic div_last;
        logic is_set;
    } stat_t;

endpackage

`default_nettype wire

/* rtl/voxel_occupancy_map.sv */
// An accepted item runs through the 16-step bit-serial dividers, then range check, two multiplies
// and store RMW; no new item is taken until it is through, and a query waits for the result slot.
// A set gives no result word. A new word is accepted while the last result waits.
// Reset: configuration returns to its defaults and a clearing pass writes MAX_SIDE**3/32
// store rows (8192 at the default size), one row a cycle, with no input accepted.
// Configuration writes are accepted in every cycle, also during the clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module voxel_occupancy_map
    import vom_pkg::*;
#(
    parameter int MAX_SIDE = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output      logic              s_tready,
    input  wire logic [55:0]       s_tdata,   // x_pos, y_pos, z_pos, occupied_value, zero pad
    input  wire logic [0:0]        s_tuser,   // action
    output      logic              m_tvalid,
    input  wire logic              m_tready,
    output      logic [7:0]        m_tdata,   // is_blocked, out_of_range, zero pad
    input  wire logic              cfg_valid,
    output      logic              cfg_ready,
    input  wire logic [CFG_AW-1:0] cfg_addr,
    input  wire logic [CFG_DW-1:0] cfg_data
);

    item_t item;
    cmd_t  cmd;
    stat_t stat;
    logic  is_blocked;
    logic  out_of_range;

    // Unpack the input word
    assign item.action         = s_tuser[0];
    assign item.x_pos          = s_tdata[15:0];
    assign item.y_pos          = s_tdata[31:16];
    assign item.z_pos          = s_tdata[47:32];
    assign item.occupied_value = s_tdata[48];

    assign cfg_ready = 1'b1;

    vom_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    vom_datapath #(
        .MAX_SIDE (MAX_SIDE)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .item         (item),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_addr     (cfg_addr),
        .cfg_data     (cfg_data),
        .is_blocked   (is_blocked),
        .out_of_range (out_of_range)
    );

    // Pack the result word
    assign m_tdata = {6'b0, out_of_range, is_blocked};

endmodule

`default_nettype wire

/* rtl/vom_store.sv */
// Occupancy store: single-port-write, registered-read row memory.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module vom_store #(
    parameter int DEPTH = 8192,
    parameter int AW    = 13,
    parameter int DW    = 32
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output      logic [DW-1:0] rd_data
);

    logic [DW-1:0] ram_reg [DEPTH];
    logic [DW-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ram_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= ram_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/vom_datapath.sv */
// Datapath: config registers, three bit-serial dividers, index arithmetic,
// store read-modify-write and the result register. Uses vom_pkg, vom_store.
`timescale 1ns / 1ps
`default_nettype none

module vom_datapath
    import vom_pkg::*;
#(
    parameter int MAX_SIDE = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cmd_t              cmd,
    output      stat_t             stat,
    input  wire item_t             item,
    input  wire logic              cfg_we,
    input  wire logic [CFG_AW-1:0] cfg_addr,
    input  wire logic [CFG_DW-1:0] cfg_data,
    output      logic              is_blocked,
    output      logic              out_of_range
);

    localparam int SIDE_W     = $clog2(MAX_SIDE + 1);
    localparam int IDX_W      = $clog2(MAX_SIDE);
    localparam int HZ_W       = $clog2(MAX_SIDE * MAX_SIDE);
    localparam int STORE_SIZE = MAX_SIDE * MAX_SIDE * MAX_SIDE;
    localparam int FLAT_W     = $clog2(STORE_SIZE);
    localparam int ROWS       = (STORE_SIZE + ROW_BITS - 1) / ROW_BITS;
    localparam int ROW_AW     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CNT_W      = $clog2(COORD_W);

    // Saturate a configured side to the store's side
    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_CFG_W-1:0] s);
        if (32'(s) > MAX_SIDE)
        begin
            return SIDE_W'(MAX_SIDE);
        end
        return SIDE_W'(s);
    endfunction

    logic [RES_W-1:0]      res_reg;
    logic [SIDE_CFG_W-1:0] gw_reg;
    logic [SIDE_CFG_W-1:0] gh_reg;
    logic [SIDE_CFG_W-1:0] gd_reg;

    logic [RES_W-1:0]  res_eff;
    logic [SIDE_W-1:0] side [3];

    logic [COORD_W-1:0] coord    [3];
    logic [COORD_W-1:0] mag_reg  [3];
    logic [RES_W-1:0]   rem_reg  [3];
    logic               neg_reg  [3];
    logic [IDX_W-1:0]   idx_reg  [3];
    logic               hit      [3];

    logic [CNT_W-1:0]  cnt_reg;
    logic [ROW_AW-1:0] clr_cnt_reg;
    logic              act_reg;
    logic              occ_reg;
    logic              inside_reg;
    logic [HZ_W-1:0]   hz_reg;
    logic [FLAT_W-1:0] flat_reg;
    logic              blocked_reg;
    logic              oor_reg;

    logic [31:0]         flat_w;
    logic [ROW_AW-1:0]   row;
    logic [ROW_SH-1:0]   bsel;
    logic [ROW_BITS-1:0] rd_row;
    logic [ROW_BITS-1:0] wr_row;
    logic                wr_en;
    logic [ROW_AW-1:0]   wr_addr;
    logic [ROW_BITS-1:0] wr_data;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= RES_W'(1);
            gw_reg  <= SIDE_CFG_W'(64);
            gh_reg  <= SIDE_CFG_W'(64);
            gd_reg  <= SIDE_CFG_W'(64);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_RESOLUTION:  res_reg <= cfg_data;
                REG_GRID_WIDTH:  gw_reg  <= cfg_data[SIDE_CFG_W-1:0];
                REG_GRID_HEIGHT: gh_reg  <= cfg_data[SIDE_CFG_W-1:0];
                REG_GRID_DEPTH:  gd_reg  <= cfg_data[SIDE_CFG_W-1:0];
            endcase
        end
    end

    // Zero resolution divides as one
    assign res_eff = (res_reg == '0) ? RES_W'(1) : res_reg;
    assign side[0] = clamp_side(gw_reg);
    assign side[1] = clamp_side(gh_reg);
    assign side[2] = clamp_side(gd_reg);

    assign coord[0] = item.x_pos;
    assign coord[1] = item.y_pos;
    assign coord[2] = item.z_pos;

    // One restoring divider lane per axis, one quotient bit a cycle
    for (genvar g = 0; g < 3; g++)
    begin : g_lane
        logic [RES_W:0]     trial;
        logic               ge;
        logic [RES_W-1:0]   rem_step;
        logic [COORD_W-1:0] mag_load;

        always_comb
        begin
            trial    = {rem_reg[g], mag_reg[g][COORD_W-1]};
            ge       = (trial >= {1'b0, res_eff});
            rem_step = ge ? RES_W'(trial - {1'b0, res_eff}) : trial[RES_W-1:0];
            mag_load = coord[g][COORD_W-1] ? (~coord[g] + 1'b1) : coord[g];
            // Negative with nonzero quotient, or beyond the side
            hit[g]   = (neg_reg[g] && (mag_reg[g] != '0))
                       || (32'(mag_reg[g]) >= 32'(side[g]));
        end

        always_ff @(posedge clk)
        begin
            if (cmd.load)
            begin
                mag_reg[g] <= mag_load;
                rem_reg[g] <= '0;
                neg_reg[g] <= coord[g][COORD_W-1];
            end
            else if (cmd.div_step)
            begin
                mag_reg[g] <= {mag_reg[g][COORD_W-2:0], ge};
                rem_reg[g] <= rem_step;
            end
            if (cmd.check)
            begin
                idx_reg[g] <= mag_reg[g][IDX_W-1:0];
            end
        end
    end

    // Step and clearing counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    // Item payload, range check and flat index
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg <= item.action;
            occ_reg <= item.occupied_value;
        end
        if (cmd.check)
        begin
            inside_reg <= !(hit[0] || hit[1] || hit[2]);
        end
        if (cmd.mul1)
        begin
            hz_reg <= HZ_W'(32'(side[1]) * 32'(idx_reg[2]) + 32'(idx_reg[1]));
        end
        if (cmd.mul2)
        begin
            flat_reg <= FLAT_W'(32'(side[0]) * 32'(hz_reg) + 32'(idx_reg[0]));
        end
        if (cmd.finish && (act_reg == ACT_QUERY))
        begin
            blocked_reg <= inside_reg ? rd_row[bsel] : 1'b1;
            oor_reg     <= !inside_reg;
        end
    end

    // Row address and bit select of the voxel
    assign flat_w = 32'(flat_reg);
    assign row    = flat_w[ROW_SH +: ROW_AW];
    assign bsel   = flat_w[ROW_SH-1:0];

    // Read-modify-write of one row; clearing pass writes zero rows
    always_comb
    begin
        wr_row       = rd_row;
        wr_row[bsel] = occ_reg;
        wr_en        = cmd.clr_step
                       || (cmd.finish && (act_reg == ACT_SET) && inside_reg);
        wr_addr      = cmd.clr_step ? clr_cnt_reg : row;
        wr_data      = cmd.clr_step ? '0 : wr_row;
    end

    vom_store #(
        .DEPTH (ROWS),
        .AW    (ROW_AW),
        .DW    (ROW_BITS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.mem_rd),
        .rd_addr (row),
        .rd_data (rd_row)
    );

    // Status to the controller
    assign stat.clr_done = (clr_cnt_reg == ROW_AW'(ROWS - 1));
    assign stat.div_last = (cnt_reg == CNT_W'(COORD_W - 1));
    assign stat.is_set   = (act_reg == ACT_SET);

    assign is_blocked   = blocked_reg;
    assign out_of_range = oor_reg;

endmodule

`default_nettype wire

/* rtl/vom_ctrl.sv */
// Controller: sequences clearing, division, indexing and the store access,
// and owns the item and result handshakes. Uses vom_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vom_ctrl
    import vom_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  s_tvalid,
    output      logic  s_tready,
    output      logic  m_tvalid,
    input  wire logic  m_tready,
    output      cmd_t  cmd,
    input  wire stat_t stat
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // State and result-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The result register is free when empty or being taken
    assign out_free = !out_valid_reg || m_tready;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        s_tready       = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.mem_rd = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // A set never waits; a query waits for the result slot
                if (stat.is_set)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;

endmodule

`default_nettype wire

/* rtl/vom_checker.sv */
// Port-level checks for voxel_occupancy_map, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module vom_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result word changed while stalled");

    // Out of range always reads as blocked
    a_oor_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (!m_tdata[1] || m_tdata[0]))
        else $error("out_of_range without is_blocked");

    // One word at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready right after an accept");

    // A new result only comes out of a busy cycle
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without work in progress");

endmodule

bind voxel_occupancy_map vom_checker u_vom_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

/* tb/voxel_occupancy_checker.sv */
// Checker for the voxel occupancy map: watches the config, item and result channels.
// Keeps its own occupancy grid and config copy, predicts each query answer, compares.
// Depends on vom_pkg for register indexes and widths.
`timescale 1ns / 1ps

module voxel_occupancy_checker
    import vom_pkg::*;
#(
    parameter int MAX_SIDE = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    input  wire logic              s_tready,
    input  wire logic [55:0]       s_tdata,   // x_pos, y_pos, z_pos, occupied_value, zero pad
    input  wire logic [0:0]        s_tuser,   // action
    input  wire logic              m_tvalid,
    input  wire logic              m_tready,
    input  wire logic [7:0]        m_tdata,   // is_blocked, out_of_range, zero pad
    input  wire logic              cfg_valid,
    input  wire logic              cfg_ready,
    input  wire logic [CFG_AW-1:0] cfg_addr,
    input  wire logic [CFG_DW-1:0] cfg_data,
    output int                     mismatch_count,
    output int                     answers_due
);

    typedef struct packed {
        logic is_blocked;
        logic out_of_range;
    } answer_t;

    // Own copy of the grid and the registers
    bit                  occ_map [0:MAX_SIDE*MAX_SIDE*MAX_SIDE-1];
    logic [RES_W-1:0]    res_q;
    logic [SIDE_CFG_W-1:0] width_q;
    logic [SIDE_CFG_W-1:0] height_q;
    logic [SIDE_CFG_W-1:0] depth_q;
    answer_t             answer_q [$];

    // Coordinate in cm to voxel index, truncating toward zero; 1 when inside [0, side)
    function automatic bit voxel_index(input logic [COORD_W-1:0] raw, input int side,
                                       output int idx);
        int cm;
        int divisor;
        cm      = $signed(raw);
        divisor = (res_q == '0) ? 1 : int'(res_q);
        idx     = cm / divisor;
        return (idx >= 0) && (idx < side);
    endfunction

    // Applies one item to the grid; returns 1 when it yields an answer
    function automatic bit predict_lookup(input logic act, input logic [COORD_W-1:0] xr,
                                          input logic [COORD_W-1:0] yr,
                                          input logic [COORD_W-1:0] zr,
                                          input logic ov, output answer_t ans);
        int w, h, d;
        int xi, yi, zi;
        int flat;
        bit in_x, in_y, in_z, in_grid;
        w       = (int'(width_q) > MAX_SIDE) ? MAX_SIDE : int'(width_q);
        h       = (int'(height_q) > MAX_SIDE) ? MAX_SIDE : int'(height_q);
        d       = (int'(depth_q) > MAX_SIDE) ? MAX_SIDE : int'(depth_q);
        in_x    = voxel_index(xr, w, xi);
        in_y    = voxel_index(yr, h, yi);
        in_z    = voxel_index(zr, d, zi);
        in_grid = in_x && in_y && in_z;
        flat    = in_grid ? xi + w * (yi + h * zi) : 0;
        ans     = '0;
        if (act == ACT_SET)
        begin
            // set inside writes the bit, set outside is dropped; never an answer
            if (in_grid)
                occ_map[flat] = ov;
            return 1'b0;
        end
        if (!in_grid)
        begin
            ans.is_blocked   = 1'b1;
            ans.out_of_range = 1'b1;
        end
        else
        begin
            ans.is_blocked   = occ_map[flat];
            ans.out_of_range = 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        answer_t want;
        answer_t fresh;
        if (!rst_n)
        begin
            res_q          = RES_W'(1);
            width_q        = SIDE_CFG_W'(64);
            height_q       = SIDE_CFG_W'(64);
            depth_q        = SIDE_CFG_W'(64);
            occ_map        = '{default: 1'b0};
            answer_q.delete();
            mismatch_count = 0;
            answers_due    = 0;
        end
        else
        begin
            // config write
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_addr)
                    REG_RESOLUTION:  res_q    = cfg_data[RES_W-1:0];
                    REG_GRID_WIDTH:  width_q  = cfg_data[SIDE_CFG_W-1:0];
                    REG_GRID_HEIGHT: height_q = cfg_data[SIDE_CFG_W-1:0];
                    REG_GRID_DEPTH:  depth_q  = cfg_data[SIDE_CFG_W-1:0];
                    default: ;
                endcase
            end

            // result word against the oldest answer
            if (m_tvalid && m_tready)
            begin
                if (answer_q.size() == 0)
                begin
                    $error("result word with no query waiting: m_tdata=%h", m_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = answer_q.pop_front();
                    if (m_tdata[0] !== want.is_blocked)
                    begin
                        $error("is_blocked: expected %0b, actual %0b",
                               want.is_blocked, m_tdata[0]);
                        mismatch_count++;
                    end
                    if (m_tdata[1] !== want.out_of_range)
                    begin
                        $error("out_of_range: expected %0b, actual %0b",
                               want.out_of_range, m_tdata[1]);
                        mismatch_count++;
                    end
                end
            end

            // accepted item
            if (s_tvalid && s_tready)
            begin
                if (predict_lookup(s_tuser[0], s_tdata[15:0], s_tdata[31:16],
                                   s_tdata[47:32], s_tdata[48], fresh))
                    answer_q.insert(answer_q.size(), fresh);
            end

            answers_due = answer_q.size();
        end
    end

endmodule

/* tb/voxel_occupancy_map_test.sv */
// Top of the voxel occupancy map test: clock, reset, stimulus, stalls and verdict.
// Instantiates voxel_occupancy_map and voxel_occupancy_checker; uses vom_pkg.
`timescale 1ns / 1ps

module voxel_occupancy_map_test;
    import vom_pkg::*;

    localparam int MAX_SIDE        = 64;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 66;
    localparam int LONG_HOLD       = 400;
    localparam int SETTLE_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT  = 50000;

    typedef struct {
        int x;
        int y;
        int z;
    } voxel_pos_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [55:0]       s_tdata   = '0;   // x_pos, y_pos, z_pos, occupied_value, zero pad
    logic [0:0]        s_tuser   = '0;   // action
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [7:0]        m_tdata;          // is_blocked, out_of_range, zero pad
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_AW-1:0] cfg_addr  = '0;
    logic [CFG_DW-1:0] cfg_data  = '0;

    int  mismatch_count;
    int  answers_due;
    int  stall_cycles = 0;
    bit  idle_en      = 1'b1;
    bit  hold_req     = 1'b0;

    // Current grid as the stimulus sees it, for aiming coordinates
    int  cur_res = 1;
    int  cur_w   = 64;
    int  cur_h   = 64;
    int  cur_d   = 64;
    voxel_pos_t recent_sets [$];

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    voxel_occupancy_map #(
        .MAX_SIDE (MAX_SIDE)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    voxel_occupancy_checker #(
        .MAX_SIDE (MAX_SIDE)
    ) i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_addr       (cfg_addr),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .answers_due    (answers_due)
    );

    // Watchdog: cycles with no word moving on any channel
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Result side: random ready bursts, plus one long hold-off on request
    initial
    begin : result_sink
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (idle_en && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    // One item word; returns at the edge where it was taken
    task automatic send_word(input logic act, input int x, input int y, input int z,
                             input bit ov);
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, ov, 16'(z), 16'(y), 16'(x)};
        s_tuser  <= act;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Stop offering, wait for all answers, then let in-flight sets finish
    task automatic settle();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (answers_due != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    function automatic int usable_side(input logic [CFG_DW-1:0] val);
        return (int'(val[SIDE_CFG_W-1:0]) > MAX_SIDE) ? MAX_SIDE : int'(val[SIDE_CFG_W-1:0]);
    endfunction

    // New grid setup, only once the block is quiet
    task automatic set_grid(input logic [CFG_DW-1:0] res, input logic [CFG_DW-1:0] w,
                            input logic [CFG_DW-1:0] h, input logic [CFG_DW-1:0] d);
        settle();
        write_reg(REG_RESOLUTION, res);
        write_reg(REG_GRID_WIDTH, w);
        write_reg(REG_GRID_HEIGHT, h);
        write_reg(REG_GRID_DEPTH, d);
        cfg_valid <= 1'b0;
        cur_res = int'(res);
        cur_w   = usable_side(w);
        cur_h   = usable_side(h);
        cur_d   = usable_side(d);
        recent_sets.delete();
    endtask

    // Coordinate mostly aimed inside the grid, some at edges, negatives and raw noise
    function automatic int pick_coord(input int side);
        int div;
        int cm;
        int kind;
        div  = (cur_res == 0) ? 1 : cur_res;
        kind = $urandom_range(0, 9);
        if (kind < 2)
            return int'($urandom_range(0, 65535)) - 32768;
        if (kind == 2)
            cm = -int'($urandom_range(1, 2 * div));
        else if (kind == 3)
            cm = side * div + int'($urandom_range(0, div - 1));
        else
            cm = int'($urandom_range(0, (side > 0) ? side - 1 : 0)) * div
                 + int'($urandom_range(0, div - 1));
        if (cm > 32767)
            cm = int'($urandom_range(0, 32767));
        return cm;
    endfunction

    function automatic logic [CFG_DW-1:0] rand_res();
        case ($urandom_range(0, 5))
            0:       return CFG_DW'(1);
            1:       return CFG_DW'(1023);
            2:       return CFG_DW'(0);
            default: return CFG_DW'($urandom_range(2, 40));
        endcase
    endfunction

    // Small sides dominate so sets and queries hit the same voxels
    function automatic logic [CFG_DW-1:0] rand_side();
        case ($urandom_range(0, 9))
            0:       return CFG_DW'(0);
            1:       return CFG_DW'(64);
            2:       return CFG_DW'($urandom_range(65, 1023));
            default: return CFG_DW'($urandom_range(1, 6));
        endcase
    endfunction

    task automatic send_random();
        voxel_pos_t pos;
        logic       act;
        bit         ov;
        act = ($urandom_range(0, 9) < 4) ? ACT_SET : ACT_QUERY;
        ov  = 1'($urandom_range(0, 1));
        if (recent_sets.size() > 0 && $urandom_range(0, 2) == 0)
            pos = recent_sets[$urandom_range(0, recent_sets.size() - 1)];
        else
        begin
            pos.x = pick_coord(cur_w);
            pos.y = pick_coord(cur_h);
            pos.z = pick_coord(cur_d);
        end
        if (act == ACT_SET)
        begin
            recent_sets.insert(recent_sets.size(), pos);
            if (recent_sets.size() > 16)
                void'(recent_sets.pop_front());
        end
        send_word(act, pos.x, pos.y, pos.z, ov);
    endtask

    initial
    begin : stimulus
        int p;
        int k;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset grid: 1 cm voxels, 64 per side
        send_word(ACT_QUERY, 0, 0, 0, 1'b0);
        send_word(ACT_SET, 0, 0, 0, 1'b1);
        send_word(ACT_QUERY, 0, 0, 0, 1'b0);
        send_word(ACT_SET, 63, 63, 63, 1'b1);
        send_word(ACT_QUERY, 63, 63, 63, 1'b0);
        send_word(ACT_QUERY, 64, 0, 0, 1'b0);
        send_word(ACT_QUERY, -1, 0, 0, 1'b0);
        send_word(ACT_QUERY, 32767, -32768, 0, 1'b0);
        send_word(ACT_SET, 64, 0, 0, 1'b1);       // outside, dropped
        send_word(ACT_QUERY, 0, 0, 63, 1'b0);
        send_word(ACT_SET, 0, 0, 0, 1'b0);
        send_word(ACT_QUERY, 0, 0, 0, 1'b0);

        // coarse voxels: small negatives truncate to index 0
        set_grid(CFG_DW'(10), CFG_DW'(64), CFG_DW'(64), CFG_DW'(64));
        send_word(ACT_SET, -9, 5, -1, 1'b1);
        send_word(ACT_QUERY, 9, 9, 9, 1'b0);
        send_word(ACT_QUERY, -10, 0, 0, 1'b0);
        send_word(ACT_QUERY, 639, 639, 639, 1'b0);
        send_word(ACT_QUERY, 640, 0, 0, 1'b0);

        // zero resolution acts as 1, oversized width saturates, upper bits masked
        set_grid(CFG_DW'(0), CFG_DW'(1023), CFG_DW'(64), CFG_DW'(10'h381));
        send_word(ACT_QUERY, 63, 0, 0, 1'b0);
        send_word(ACT_QUERY, 64, 0, 0, 1'b0);
        send_word(ACT_QUERY, 0, 0, 1, 1'b0);
        send_word(ACT_SET, 5, 5, 0, 1'b1);
        send_word(ACT_QUERY, 5, 5, 0, 1'b0);

        // widest voxel, zero height blocks every voxel
        set_grid(CFG_DW'(1023), CFG_DW'(1), CFG_DW'(0), CFG_DW'(1));
        send_word(ACT_QUERY, 1022, 0, 0, 1'b0);
        send_word(ACT_SET, 0, 0, 0, 1'b1);

        // single voxel grid
        set_grid(CFG_DW'(1023), CFG_DW'(1), CFG_DW'(1), CFG_DW'(1));
        send_word(ACT_QUERY, 1022, -1022, 1022, 1'b0);
        send_word(ACT_QUERY, 32767, 0, 0, 1'b0);

        // random phases; first one with a long result hold-off, last with no idling
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == 0)
                set_grid(CFG_DW'(1), CFG_DW'(2), CFG_DW'(3), CFG_DW'(4));
            else if (p == RANDOM_PHASES - 1)
                set_grid(CFG_DW'(3), CFG_DW'(5), CFG_DW'(5), CFG_DW'(5));
            else
                set_grid(rand_res(), rand_side(), rand_side(), rand_side());
            if (p == 0)
                hold_req = 1'b1;
            if (p == RANDOM_PHASES - 1)
                idle_en = 1'b0;
            for (k = 0; k < ITEMS_PER_PHASE; k++)
                send_random();
        end

        settle();
        if (mismatch_count == 0 && answers_due == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/vom_pkg.sv
rtl/vom_store.sv
rtl/vom_datapath.sv
rtl/vom_ctrl.sv
rtl/voxel_occupancy_map.sv
rtl/vom_checker.sv
tb/voxel_occupancy_checker.sv
tb/voxel_occupancy_map_test.sv
